/* sv/tagged_request_fifo_top_defines.svh */
`ifndef TAGGED_REQUEST_FIFO_TOP_DEFINES_SVH
`define TAGGED_REQUEST_FIFO_TOP_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define TRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked at every clock edge out of reset
`define TRF_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* sv/trf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package trf_pkg;

  localparam int HANDLE_BITS = 16;
  localparam int TAG_BITS    = 8;
  localparam int KIND_BITS   = 3;
  localparam int STATUS_BITS = 2;
  localparam int ENTRY_BITS  = 5;

  localparam logic [KIND_BITS-1:0] KIND_ADD       = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_POP       = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_PEEK_HEAD = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_PEEK_TAIL = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_DELETE    = 3'd4;

  localparam logic [STATUS_BITS-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_FULL     = 2'd2;
  localparam logic [STATUS_BITS-1:0] STATUS_NO_MATCH = 2'd3;

  typedef struct packed {
    logic [KIND_BITS-1:0]   kind;
    logic [HANDLE_BITS-1:0] request_handle;
    logic [TAG_BITS-1:0]    owner_tag;
  } trf_in_t;

  typedef struct packed {
    logic                   found;
    logic [HANDLE_BITS-1:0] handle_out;
    logic [TAG_BITS-1:0]    tag_out;
    logic [STATUS_BITS-1:0] status;
    logic [ENTRY_BITS-1:0]  entry_count;
    logic                   last;
  } trf_out_t;

endpackage

`default_nettype wire

/* sv/tagged_request_fifo_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Tagged request FIFO: a queue of request handles with owner tags, kept as a linked list
// in a DEPTH-slot store with a free-slot stack. Add, pop, peek head, peek tail and an
// undefined kind first read the link and data memories, then write back and load the
// result register. A delete walks the list (one memory read and one link write-back per
// entry), then emits each removed handle through a removed-slot memory read, a data
// memory read and a result load; a delete that removes nothing gives its single result
// after the walk. A stall on the result side holds the block in its result-loading step.
// The link memory keeps one valid bit per slot, so reset takes effect at once with no
// clearing pass.

`include "tagged_request_fifo_top_defines.svh"

module tagged_request_fifo_top #(
  parameter int DEPTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire trf_pkg::trf_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output trf_pkg::trf_out_t     out_data
);

  localparam int SLOT_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int ENTRY_W = trf_pkg::ENTRY_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_EMIT_IDX,
    ST_EMIT_DATA,
    ST_EMIT_OUT
  } state_t;

  function automatic logic [ENTRY_W-1:0] to_entry(input logic [CNT_W-1:0] c);
    logic [ENTRY_W+CNT_W-1:0] wide;
    wide = {{ENTRY_W{1'b0}}, c};
    return wide[ENTRY_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] link_default(input logic [SLOT_W-1:0] a);
    return (a == SLOT_W'(DEPTH - 1)) ? '0 : SLOT_W'(a + 1'b1);
  endfunction

  // control and payload registers
  state_t              state_r, state_nxt;
  logic [SLOT_W-1:0]   head_r, head_nxt;
  logic [SLOT_W-1:0]   tail_r, tail_nxt;
  logic [SLOT_W-1:0]   free_head_r, free_head_nxt;
  logic [CNT_W-1:0]    free_cnt_r, free_cnt_nxt;
  logic [CNT_W-1:0]    qcnt_r, qcnt_nxt;
  logic [SLOT_W-1:0]   cur_r, cur_nxt;
  logic [SLOT_W-1:0]   prev_r, prev_nxt;
  logic [CNT_W-1:0]    walk_i_r, walk_i_nxt;
  logic [CNT_W-1:0]    kept_r, kept_nxt;
  logic [CNT_W-1:0]    rm_cnt_r, rm_cnt_nxt;
  logic [CNT_W-1:0]    emit_k_r, emit_k_nxt;
  logic                out_valid_r, out_valid_nxt;
  trf_pkg::trf_in_t    item_r, item_nxt;
  trf_pkg::trf_out_t   out_r, out_nxt;

  // memories
  logic [trf_pkg::HANDLE_BITS-1:0] handle_mem [DEPTH];
  logic [trf_pkg::TAG_BITS-1:0]    tag_mem    [DEPTH];
  logic [SLOT_W-1:0]               link_mem   [DEPTH];
  logic [SLOT_W-1:0]               rm_mem     [DEPTH];
  logic [DEPTH-1:0]                link_vld_r;

  logic                            data_we, data_re;
  logic [SLOT_W-1:0]               data_wa, data_ra;
  logic [trf_pkg::HANDLE_BITS-1:0] handle_q;
  logic [trf_pkg::TAG_BITS-1:0]    tag_q;

  logic                            link_we, link_re;
  logic [SLOT_W-1:0]               link_wa, link_wd, link_ra;
  logic [SLOT_W-1:0]               link_q, link_addr_q;
  logic                            link_vld_q;
  logic [SLOT_W-1:0]               link_rd;

  logic                            rm_we, rm_re;
  logic [SLOT_W-1:0]               rm_wa, rm_wd, rm_ra, rm_q;

  logic                            out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign link_rd   = link_vld_q ? link_q : link_default(link_addr_q);

  always_comb begin
    trf_pkg::trf_out_t res;
    logic              last_step;
    logic [CNT_W-1:0]  kept_v;
    logic [CNT_W-1:0]  rm_v;
    logic [SLOT_W-1:0] prev_v;
    logic [CNT_W-1:0]  cnt_v;

    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    free_head_nxt = free_head_r;
    free_cnt_nxt  = free_cnt_r;
    qcnt_nxt      = qcnt_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    walk_i_nxt    = walk_i_r;
    kept_nxt      = kept_r;
    rm_cnt_nxt    = rm_cnt_r;
    emit_k_nxt    = emit_k_r;
    item_nxt      = item_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    data_we = 1'b0;
    data_wa = '0;
    data_re = 1'b0;
    data_ra = '0;
    link_we = 1'b0;
    link_wa = '0;
    link_wd = '0;
    link_re = 1'b0;
    link_ra = '0;
    rm_we   = 1'b0;
    rm_wa   = '0;
    rm_wd   = '0;
    rm_re   = 1'b0;
    rm_ra   = '0;

    res       = '0;
    last_step = 1'b0;
    kept_v    = kept_r;
    rm_v      = rm_cnt_r;
    prev_v    = prev_r;
    cnt_v     = qcnt_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = ST_EXEC;
          link_re   = 1'b1;
          data_re   = 1'b1;
          link_ra   = (in_data.kind == trf_pkg::KIND_ADD) ? free_head_r : head_r;
          data_ra   = (in_data.kind == trf_pkg::KIND_PEEK_TAIL) ? tail_r : head_r;
        end
      end

      ST_EXEC: begin
        if (item_r.kind == trf_pkg::KIND_DELETE) begin
          cur_nxt    = head_r;
          prev_nxt   = '0;
          walk_i_nxt = '0;
          kept_nxt   = '0;
          rm_cnt_nxt = '0;
          state_nxt  = (qcnt_r == '0) ? ST_EMIT_OUT : ST_WALK_RD;
        end else if (out_free) begin
          res.last = 1'b1;
          case (item_r.kind)
            trf_pkg::KIND_ADD: begin
              if (free_cnt_r == '0) begin
                res.status = trf_pkg::STATUS_FULL;
              end else begin
                free_head_nxt = link_rd;
                free_cnt_nxt  = CNT_W'(free_cnt_r - 1'b1);
                data_we       = 1'b1;
                data_wa       = free_head_r;
                if (qcnt_r == '0) begin
                  head_nxt = free_head_r;
                end else begin
                  link_we = 1'b1;
                  link_wa = tail_r;
                  link_wd = free_head_r;
                end
                tail_nxt = free_head_r;
                cnt_v    = CNT_W'(qcnt_r + 1'b1);
                qcnt_nxt = cnt_v;
              end
            end
            trf_pkg::KIND_POP, trf_pkg::KIND_PEEK_HEAD, trf_pkg::KIND_PEEK_TAIL: begin
              if (qcnt_r == '0) begin
                res.status = trf_pkg::STATUS_EMPTY;
              end else begin
                res.found      = 1'b1;
                res.handle_out = handle_q;
                res.tag_out    = tag_q;
                if (item_r.kind == trf_pkg::KIND_POP) begin
                  head_nxt      = link_rd;
                  link_we       = 1'b1;
                  link_wa       = head_r;
                  link_wd       = free_head_r;
                  free_head_nxt = head_r;
                  free_cnt_nxt  = CNT_W'(free_cnt_r + 1'b1);
                  cnt_v         = CNT_W'(qcnt_r - 1'b1);
                  qcnt_nxt      = cnt_v;
                  if (cnt_v == '0) begin
                    head_nxt = '0;
                    tail_nxt = '0;
                  end
                end
              end
            end
            default: begin
              res.status = trf_pkg::STATUS_OK;
            end
          endcase
          res.entry_count = to_entry(cnt_v);
          out_nxt         = res;
          out_valid_nxt   = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end

      ST_WALK_RD: begin
        data_re   = 1'b1;
        data_ra   = cur_r;
        link_re   = 1'b1;
        link_ra   = cur_r;
        state_nxt = ST_WALK_CHK;
      end

      ST_WALK_CHK: begin
        last_step = (CNT_W'(walk_i_r + 1'b1) == qcnt_r);
        if (tag_q == item_r.owner_tag) begin
          link_we       = 1'b1;
          link_wa       = cur_r;
          link_wd       = free_head_r;
          free_head_nxt = cur_r;
          free_cnt_nxt  = CNT_W'(free_cnt_r + 1'b1);
          rm_we         = 1'b1;
          rm_wa         = rm_cnt_r[SLOT_W-1:0];
          rm_wd         = cur_r;
          rm_v          = CNT_W'(rm_cnt_r + 1'b1);
        end else begin
          if (kept_r == '0) begin
            head_nxt = cur_r;
          end else begin
            link_we = 1'b1;
            link_wa = prev_r;
            link_wd = cur_r;
          end
          prev_v = cur_r;
          kept_v = CNT_W'(kept_r + 1'b1);
        end
        cur_nxt    = link_rd;
        prev_nxt   = prev_v;
        kept_nxt   = kept_v;
        rm_cnt_nxt = rm_v;
        walk_i_nxt = CNT_W'(walk_i_r + 1'b1);
        if (last_step) begin
          qcnt_nxt = kept_v;
          if (kept_v == '0) begin
            head_nxt = '0;
            tail_nxt = '0;
          end else begin
            tail_nxt = prev_v;
          end
          emit_k_nxt = '0;
          state_nxt  = (rm_v == '0) ? ST_EMIT_OUT : ST_EMIT_IDX;
        end else begin
          state_nxt = ST_WALK_RD;
        end
      end

      ST_EMIT_IDX: begin
        rm_re     = 1'b1;
        rm_ra     = emit_k_r[SLOT_W-1:0];
        state_nxt = ST_EMIT_DATA;
      end

      ST_EMIT_DATA: begin
        data_re   = 1'b1;
        data_ra   = rm_q;
        state_nxt = ST_EMIT_OUT;
      end

      ST_EMIT_OUT: begin
        if (out_free) begin
          res.entry_count = to_entry(qcnt_r);
          if (rm_cnt_r == '0) begin
            res.status = trf_pkg::STATUS_NO_MATCH;
            res.last   = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            res.found      = 1'b1;
            res.handle_out = handle_q;
            res.tag_out    = tag_q;
            res.status     = trf_pkg::STATUS_OK;
            res.last       = (CNT_W'(emit_k_r + 1'b1) == rm_cnt_r);
            emit_k_nxt     = CNT_W'(emit_k_r + 1'b1);
            state_nxt      = res.last ? ST_IDLE : ST_EMIT_IDX;
          end
          out_nxt       = res;
          out_valid_nxt = 1'b1;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      free_head_r <= '0;
      free_cnt_r  <= CNT_W'(DEPTH);
      qcnt_r      <= '0;
      out_valid_r <= 1'b0;
      walk_i_r    <= '0;
      kept_r      <= '0;
      rm_cnt_r    <= '0;
      emit_k_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      free_head_r <= free_head_nxt;
      free_cnt_r  <= free_cnt_nxt;
      qcnt_r      <= qcnt_nxt;
      out_valid_r <= out_valid_nxt;
      walk_i_r    <= walk_i_nxt;
      kept_r      <= kept_nxt;
      rm_cnt_r    <= rm_cnt_nxt;
      emit_k_r    <= emit_k_nxt;
    end
    cur_r  <= cur_nxt;
    prev_r <= prev_nxt;
    item_r <= item_nxt;
    out_r  <= out_nxt;
  end

  // handle and tag store
  always_ff @(posedge clk) begin
    if (data_we) begin
      handle_mem[data_wa] <= item_r.request_handle;
      tag_mem[data_wa]    <= item_r.owner_tag;
    end
    if (data_re) begin
      handle_q <= handle_mem[data_ra];
      tag_q    <= tag_mem[data_ra];
    end
  end

  // link store, unwritten slots read as the reset chain
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (link_re) begin
      link_q      <= link_mem[link_ra];
      link_addr_q <= link_ra;
      link_vld_q  <= link_vld_r[link_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_vld_r <= '0;
    end else if (link_we) begin
      link_vld_r[link_wa] <= 1'b1;
    end
  end

  // slots removed by a delete, in queue order
  always_ff @(posedge clk) begin
    if (rm_we) begin
      rm_mem[rm_wa] <= rm_wd;
    end
    if (rm_re) begin
      rm_q <= rm_mem[rm_ra];
    end
  end

  `TRF_ASSERT_IMPLY(a_slot_balance,
    state_r != ST_WALK_RD && state_r != ST_WALK_CHK,
    ({1'b0, free_cnt_r} + {1'b0, qcnt_r}) == (CNT_W + 1)'(DEPTH),
    "free and queued counts do not add up to the depth")
  `TRF_ASSERT_IMPLY(a_empty_pointers,
    state_r == ST_IDLE && qcnt_r == '0,
    head_r == '0 && tail_r == '0,
    "empty queue with nonzero head or tail")
  `TRF_ASSERT_IMPLY(a_emit_bound,
    state_r == ST_EMIT_IDX || state_r == ST_EMIT_DATA,
    emit_k_r < rm_cnt_r,
    "removed-handle index past the removed count")
  `TRF_ASSERT(a_count_bound, qcnt_r <= CNT_W'(DEPTH), "queued count exceeds depth")

endmodule

`default_nettype wire

/* tb/trf_queue_checker.sv */
`timescale 1ns / 1ps

module trf_queue_checker #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  trf_pkg::trf_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  trf_pkg::trf_out_t out_data,
  output int                fail_count,
  output int                pending_results,
  output int                results_checked,
  output int                full_drops,
  output int                deleted_handles
);
  import trf_pkg::*;

  typedef struct packed {
    logic [HANDLE_BITS-1:0] handle;
    logic [TAG_BITS-1:0]    tag;
  } queued_req_t;

  queued_req_t queued_reqs[$];
  trf_out_t    expected_results[$];

  function automatic trf_out_t result_word(logic found, logic [HANDLE_BITS-1:0] handle,
                                           logic [TAG_BITS-1:0] tag,
                                           logic [STATUS_BITS-1:0] status, logic last);
    trf_out_t r;
    r.found       = found;
    r.handle_out  = handle;
    r.tag_out     = tag;
    r.status      = status;
    r.entry_count = ENTRY_BITS'(queued_reqs.size());
    r.last        = last;
    return r;
  endfunction

  function automatic void predict_transfer(trf_in_t req);
    queued_req_t kept[$];
    queued_req_t removed[$];
    queued_req_t e;
    case (req.kind)
      KIND_ADD: begin
        if (queued_reqs.size() >= DEPTH) begin
          full_drops++;
          expected_results.push_back(result_word(1'b0, '0, '0, STATUS_FULL, 1'b1));
        end else begin
          queued_reqs.push_back('{req.request_handle, req.owner_tag});
          expected_results.push_back(result_word(1'b0, '0, '0, STATUS_OK, 1'b1));
        end
      end
      KIND_POP, KIND_PEEK_HEAD, KIND_PEEK_TAIL: begin
        if (queued_reqs.size() == 0) begin
          expected_results.push_back(result_word(1'b0, '0, '0, STATUS_EMPTY, 1'b1));
        end else begin
          e = (req.kind == KIND_PEEK_TAIL) ? queued_reqs[$] : queued_reqs[0];
          if (req.kind == KIND_POP) void'(queued_reqs.pop_front());
          expected_results.push_back(result_word(1'b1, e.handle, e.tag, STATUS_OK, 1'b1));
        end
      end
      KIND_DELETE: begin
        foreach (queued_reqs[i]) begin
          if (queued_reqs[i].tag == req.owner_tag) removed.push_back(queued_reqs[i]);
          else kept.push_back(queued_reqs[i]);
        end
        queued_reqs = kept;
        deleted_handles += removed.size();
        if (removed.size() == 0) begin
          expected_results.push_back(result_word(1'b0, '0, '0, STATUS_NO_MATCH, 1'b1));
        end else begin
          foreach (removed[i]) begin
            expected_results.push_back(result_word(1'b1, removed[i].handle, removed[i].tag,
                                                   STATUS_OK, i == removed.size() - 1));
          end
        end
      end
      default: begin
        expected_results.push_back(result_word(1'b0, '0, '0, STATUS_OK, 1'b1));
      end
    endcase
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    trf_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing outstanding: handle_out %0d",
                 out_data.handle_out);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("found", want.found, out_data.found);
          check_field("handle_out", want.handle_out, out_data.handle_out);
          check_field("tag_out", want.tag_out, out_data.tag_out);
          check_field("status", want.status, out_data.status);
          check_field("entry_count", want.entry_count, out_data.entry_count);
          check_field("last", want.last, out_data.last);
          results_checked++;
        end
      end
      if (in_valid && !in_stall) predict_transfer(in_data);
    end
    pending_results = expected_results.size();
  end

endmodule

/* tb/tb_tagged_request_fifo_top.sv */
`timescale 1ns / 1ps

module tb_tagged_request_fifo_top;
  import trf_pkg::*;

  localparam int DEPTH        = 16;
  localparam int RANDOM_ITEMS = 250;
  localparam int LONG_HOLD    = 200;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 80;

  localparam logic [KIND_BITS-1:0] KIND_UNDEF_LO = 3'd5;
  localparam logic [KIND_BITS-1:0] KIND_UNDEF_HI = 3'd7;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  trf_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  trf_out_t out_data;

  int fail_count;
  int pending_results;
  int results_checked;
  int full_drops;
  int deleted_handles;
  int kind_hits[8];
  int idle_cycles;
  bit hold_go;
  bit hold_taken;
  bit no_gaps;
  logic [TAG_BITS-1:0] tag_pool[3];

  tagged_request_fifo_top #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  trf_queue_checker #(.DEPTH(DEPTH)) u_queue_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .results_checked (results_checked),
    .full_drops      (full_drops),
    .deleted_handles (deleted_handles)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic trf_in_t make_item(logic [KIND_BITS-1:0] kind,
                                        logic [HANDLE_BITS-1:0] handle,
                                        logic [TAG_BITS-1:0] tag);
    trf_in_t it;
    it.kind           = kind;
    it.request_handle = handle;
    it.owner_tag      = tag;
    return it;
  endfunction

  function automatic trf_in_t random_item(input int add_pct);
    trf_in_t it;
    int r;
    it.request_handle = HANDLE_BITS'($urandom);
    r = $urandom_range(0, 19);
    if (r == 0) it.request_handle = '0;
    else if (r == 1) it.request_handle = '1;
    it.owner_tag = ($urandom_range(0, 99) < 85) ? tag_pool[$urandom_range(0, 2)]
                                                : TAG_BITS'($urandom);
    r = $urandom_range(0, 99);
    if (r < add_pct) begin
      it.kind = KIND_ADD;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 35) it.kind = KIND_POP;
      else if (r < 50) it.kind = KIND_PEEK_HEAD;
      else if (r < 65) it.kind = KIND_PEEK_TAIL;
      else if (r < 95) it.kind = KIND_DELETE;
      else it.kind = KIND_BITS'($urandom_range(KIND_UNDEF_LO, KIND_UNDEF_HI));
    end
    return it;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send(input trf_in_t it);
    in_data  <= it;
    in_valid <= 1'b1;
    kind_hits[it.kind]++;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!no_gaps) begin
      if (r < 50) pause(0);
      else if (r < 85) pause($urandom_range(1, 3));
      else if (r < 97) pause($urandom_range(4, 10));
      else pause($urandom_range(20, 40));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait (pending_results == 0);
    @(negedge clk);
  endtask

  // result side: stall modes chosen at random, plus one long hold
  initial begin
    int stall_left;
    int mode;
    int mode_left;
    int r;
    out_stall  = 1'b0;
    stall_left = 0;
    mode       = 0;
    mode_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      if (stall_left == 0) begin
        r = $urandom_range(0, 99);
        case (mode)
          1: if (r < 20) stall_left = $urandom_range(1, 3);
          2: begin
            if (r < 25) stall_left = $urandom_range(1, 4);
            else if (r < 29) stall_left = $urandom_range(15, 40);
          end
          default: stall_left = 0;
        endcase
      end
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: %0d cycles without a transfer", IDLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    trf_in_t it;
    int counted;
    int add_pct;
    int r;
    logic [TAG_BITS-1:0] fill_tag;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty queue cases and undefined kinds
    send(make_item(KIND_POP, '0, '0));
    send(make_item(KIND_PEEK_HEAD, '1, '1));
    send(make_item(KIND_PEEK_TAIL, '0, '1));
    send(make_item(KIND_DELETE, '1, '0));
    for (int k = KIND_UNDEF_LO; k <= KIND_UNDEF_HI; k++) begin
      send(make_item(KIND_BITS'(k), HANDLE_BITS'($urandom), TAG_BITS'($urandom)));
    end
    // field extremes, then delete that keeps one entry in the middle
    send(make_item(KIND_ADD, '1, '1));
    send(make_item(KIND_ADD, '0, '0));
    send(make_item(KIND_ADD, 16'h1234, '1));
    send(make_item(KIND_PEEK_HEAD, '0, '0));
    send(make_item(KIND_PEEK_TAIL, '0, '0));
    send(make_item(KIND_DELETE, '0, 8'h55));
    send(make_item(KIND_DELETE, '0, '1));
    send(make_item(KIND_PEEK_TAIL, '0, '0));
    send(make_item(KIND_POP, '0, '0));
    send(make_item(KIND_PEEK_HEAD, '0, '0));
    drain();

    // fill past capacity, starting while the result side is held off
    fill_tag = TAG_BITS'($urandom);
    hold_go  = 1'b1;
    wait (hold_taken);
    for (int i = 0; i < DEPTH + 4; i++) begin
      send(make_item(KIND_ADD, HANDLE_BITS'($urandom),
                     (i < DEPTH) ? fill_tag : TAG_BITS'($urandom)));
    end
    send(make_item(KIND_PEEK_TAIL, '0, '0));
    drain();
    send(make_item(KIND_DELETE, '0, fill_tag));
    drain();

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      foreach (tag_pool[i]) tag_pool[i] = TAG_BITS'($urandom);
      r = $urandom_range(0, 5);
      if (r == 0) tag_pool[0] = '0;
      else if (r == 1) tag_pool[0] = '1;
      r = $urandom_range(0, 2);
      add_pct = (r == 0) ? 45 : (r == 1) ? 80 : 20;
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat (30) begin
        it = random_item(add_pct);
        send(it);
        if (it.kind <= KIND_DELETE) counted++;
        random_gap();
      end
      if ($urandom_range(0, 1) == 1) drain();
    end
    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("run covered %0d adds, %0d pops, %0d/%0d head/tail peeks, %0d deletes, %0d odd kinds",
             kind_hits[KIND_ADD], kind_hits[KIND_POP], kind_hits[KIND_PEEK_HEAD],
             kind_hits[KIND_PEEK_TAIL], kind_hits[KIND_DELETE],
             kind_hits[5] + kind_hits[6] + kind_hits[7]);
    $display("%0d results compared, %0d adds dropped when full, %0d handles removed by delete",
             results_checked, full_drops, deleted_handles);
    if (fail_count == 0 && pending_results == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/trf_pkg.sv
sv/tagged_request_fifo_top.sv
tb/trf_queue_checker.sv
tb/tb_tagged_request_fifo_top.sv
